// ===== rtl/contact_angle_trilinear_interp_assert.svh =====
// Assertion macros for the contact-angle interpolator.
`ifndef CONTACT_ANGLE_TRILINEAR_INTERP_ASSERT_SVH
`define CONTACT_ANGLE_TRILINEAR_INTERP_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define CATI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define CATI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/cati_pkg.sv =====
// Shared types, constants and the arctangent table of the contact-angle interpolator.
package cati_pkg;

  localparam int POS_BITS   = 17;
  localparam int GRAD_BITS  = 16;
  localparam int ANGLE_BITS = 15;
  localparam int FRAC_MAX   = 16;
  localparam int ADDR_MAX   = 24;

  localparam logic [ANGLE_BITS-1:0] ANGLE_MAX = 15'd25736;
  localparam int PI_Q16 = 205887;
  localparam int CORDIC_STEPS = 17;

  // Operation classes decided by the front end.
  typedef enum logic [1:0] {
    OP_LOAD,
    OP_QUERY,
    OP_MISS
  } cati_op_t;

  // One classified request as it travels through the queue.
  typedef struct packed {
    cati_op_t                     op;
    logic [ADDR_MAX-1:0]          addr;
    logic [FRAC_MAX-1:0]          fx;
    logic [FRAC_MAX-1:0]          fy;
    logic [FRAC_MAX-1:0]          fz;
    logic signed [GRAD_BITS-1:0]  fgx;
    logic signed [GRAD_BITS-1:0]  fgy;
    logic signed [GRAD_BITS-1:0]  fgz;
    logic signed [GRAD_BITS-1:0]  sgx;
    logic signed [GRAD_BITS-1:0]  sgy;
    logic signed [GRAD_BITS-1:0]  sgz;
  } cati_item_t;

  // Arctangent of 2^-i in units of 2^-16 rad.
  function automatic logic [16:0] atan_q16(input logic [4:0] i);
    logic [16:0] v;
    unique case (i)
      5'd0:  v = 17'd51472;
      5'd1:  v = 17'd30385;
      5'd2:  v = 17'd16055;
      5'd3:  v = 17'd8150;
      5'd4:  v = 17'd4091;
      5'd5:  v = 17'd2047;
      5'd6:  v = 17'd1024;
      5'd7:  v = 17'd512;
      5'd8:  v = 17'd256;
      5'd9:  v = 17'd128;
      5'd10: v = 17'd64;
      5'd11: v = 17'd32;
      5'd12: v = 17'd16;
      5'd13: v = 17'd8;
      5'd14: v = 17'd4;
      5'd15: v = 17'd2;
      5'd16: v = 17'd1;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/cati_front.sv =====
// Front end: takes requests, classifies them and computes the grid address.
module cati_front import cati_pkg::*; #(
  parameter int GRID_X    = 32,
  parameter int GRID_Y    = 32,
  parameter int GRID_Z    = 32,
  parameter int FRAC_BITS = 12
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        kind,
  input  logic [POS_BITS-1:0]         pos_x,
  input  logic [POS_BITS-1:0]         pos_y,
  input  logic [POS_BITS-1:0]         pos_z,
  input  logic signed [GRAD_BITS-1:0] fluid_gx,
  input  logic signed [GRAD_BITS-1:0] fluid_gy,
  input  logic signed [GRAD_BITS-1:0] fluid_gz,
  input  logic signed [GRAD_BITS-1:0] solid_gx,
  input  logic signed [GRAD_BITS-1:0] solid_gy,
  input  logic signed [GRAD_BITS-1:0] solid_gz,
  input  logic                        q_full,
  output logic                        q_push,
  output cati_item_t                  q_item
);

  localparam int IB = POS_BITS - FRAC_BITS;

  logic [IB-1:0] ix, iy, iz;
  logic          load_in, query_in, accept;
  logic [31:0]   lin;
  cati_item_t    item_c;
  cati_item_t    stage;
  logic          stage_valid;

  // Integer parts select the grid point, fraction bits the offsets.
  assign ix = pos_x[POS_BITS-1:FRAC_BITS];
  assign iy = pos_y[POS_BITS-1:FRAC_BITS];
  assign iz = pos_z[POS_BITS-1:FRAC_BITS];

  assign load_in  = (32'(ix) < 32'(GRID_X)) && (32'(iy) < 32'(GRID_Y)) &&
                    (32'(iz) < 32'(GRID_Z));
  assign query_in = (32'(ix) + 32'd1 < 32'(GRID_X)) && (32'(iy) + 32'd1 < 32'(GRID_Y)) &&
                    (32'(iz) + 32'd1 < 32'(GRID_Z));

  // Linear address of the point, x fastest.
  assign lin = (32'(iz) * 32'(GRID_Y) + 32'(iy)) * 32'(GRID_X) + 32'(ix);

  // Classified request built from the ports.
  always_comb begin
    item_c.op   = kind ? (query_in ? OP_QUERY : OP_MISS) : OP_LOAD;
    item_c.addr = lin[ADDR_MAX-1:0];
    item_c.fx   = FRAC_MAX'(pos_x[FRAC_BITS-1:0]);
    item_c.fy   = FRAC_MAX'(pos_y[FRAC_BITS-1:0]);
    item_c.fz   = FRAC_MAX'(pos_z[FRAC_BITS-1:0]);
    item_c.fgx  = fluid_gx;
    item_c.fgy  = fluid_gy;
    item_c.fgz  = fluid_gz;
    item_c.sgx  = solid_gx;
    item_c.sgy  = solid_gy;
    item_c.sgz  = solid_gz;
  end

  // The stage only blocks new requests while it cannot drain into the queue.
  assign busy   = stage_valid && q_full;
  assign accept = start && !busy;
  assign q_push = stage_valid && !q_full;
  assign q_item = stage;

  // Staging register; loads outside the grid are dropped here.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      if (q_push) begin
        stage_valid <= 1'b0;
      end
      if (accept && (kind || load_in)) begin
        stage_valid <= 1'b1;
      end
    end
    if (accept) begin
      stage <= item_c;
    end
  end

endmodule

// ===== rtl/cati_queue.sv =====
// Two-entry queue between the front end and the back end.
module cati_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);

  logic [W-1:0] slots [2];
  logic         wp, rp;
  logic [1:0]   cnt;

  assign full  = (cnt == 2'd2);
  assign empty = (cnt == 2'd0);
  assign dout  = slots[rp];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      cnt <= cnt + 2'(push) - 2'(pop);
    end
    if (push) begin
      slots[wp] <= din;
    end
  end

endmodule

// ===== rtl/cati_isqrt.sv =====
// Iterative integer square root of a 64-bit value, one result bit per cycle.
module cati_isqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] rad,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] n, res, bitv;
  logic [4:0]  cnt;
  logic        busy;

  assign root = res[31:0];

  // Digit-by-digit recurrence over 32 two-bit groups.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 5'd31) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
    if (start) begin
      n    <= rad;
      res  <= '0;
      bitv <= 64'd1 << 62;
      cnt  <= '0;
    end else if (busy) begin
      if (n >= res + bitv) begin
        n   <= n - (res + bitv);
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
      cnt  <= cnt + 5'd1;
    end
  end

endmodule

// ===== rtl/cati_back.sv =====
// Back end: grid store, cosine computation for loads, interpolation and arccosine for queries.
module cati_back import cati_pkg::*; #(
  parameter int GRID_X     = 32,
  parameter int GRID_Y     = 32,
  parameter int GRID_Z     = 32,
  parameter int FRAC_BITS  = 12,
  parameter int VALUE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_empty,
  input  cati_item_t            q_item,
  output logic                  q_pop,
  output logic                  done,
  output logic [ANGLE_BITS-1:0] angle,
  output logic                  status,
  output logic                  degenerate_corner
);

  localparam int DEPTH = GRID_X * GRID_Y * GRID_Z;
  localparam int AW    = $clog2(DEPTH);
  localparam int VB    = VALUE_BITS;
  localparam int EW    = VB + 1;
  localparam int XW    = VB + 1;
  localparam int ZW    = 20;
  localparam int LW    = VB + FRAC_BITS + 2;
  localparam logic [AW-1:0] STEP_Y = AW'(GRID_X);
  localparam logic [AW-1:0] STEP_Z = AW'(GRID_X * GRID_Y);
  localparam logic [VB-2:0] ONE    = (VB-1)'(1) << (VB - 2);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_PROD, S_PSQRT, S_DIV, S_WRITE,
    S_READ, S_LERP, S_SQR, S_ASQRT, S_CORDIC, S_FINISH
  } state_t;

  state_t                state;
  logic [5:0]            cnt;
  cati_item_t            item;
  logic signed [33:0]    dot;
  logic [31:0]           nf, ns;
  logic [63:0]           rad, num, den_sh;
  logic [VB-2:0]         q;
  logic                  ld_deg;
  logic signed [VB-1:0]  lv [8];
  logic                  deg;
  logic                  neg;
  logic [VB-2:0]         ac;
  logic signed [XW-1:0]  x, y;
  logic signed [ZW-1:0]  z;
  logic                  sq_start, sq_done;
  logic [31:0]           sq_root;

  logic [EW-1:0]         mem [DEPTH];
  logic [EW-1:0]         mem_rd;
  logic [AW-1:0]         mem_addr, off;
  logic                  mem_we;
  logic [EW-1:0]         mem_wd;

  logic signed [GRAD_BITS-1:0] ma, mb;
  logic signed [31:0]          prod;
  logic [33:0]                 adot;
  logic [VB-2:0]               mag;
  logic signed [VB-1:0]        mag_s, cos_w;
  logic [FRAC_BITS-1:0]        fsel;
  logic signed [VB:0]          diff;
  logic signed [LW-1:0]        t, lres;
  logic signed [VB-1:0]        lerp_r, cclamp;
  logic [2:0]                  ins;
  logic signed [XW-1:0]        xs, ys;
  logic signed [ZW-1:0]        atan_s, zz, zc, za;
  logic [2*VB-3:0]             acsq;

  cati_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .rad   (rad),
    .done  (sq_done),
    .root  (sq_root)
  );

  assign q_pop = (state == S_IDLE) && !q_empty;

  // Shared 16x16 multiplier for the dot product and the two squared norms.
  always_comb begin
    unique case (cnt)
      6'd0:    begin ma = item.fgx; mb = item.sgx; end
      6'd1:    begin ma = item.fgy; mb = item.sgy; end
      6'd2:    begin ma = item.fgz; mb = item.sgz; end
      6'd3:    begin ma = item.fgx; mb = item.fgx; end
      6'd4:    begin ma = item.fgy; mb = item.fgy; end
      6'd5:    begin ma = item.fgz; mb = item.fgz; end
      6'd6:    begin ma = item.sgx; mb = item.sgx; end
      6'd7:    begin ma = item.sgy; mb = item.sgy; end
      default: begin ma = item.sgz; mb = item.sgz; end
    endcase
    prod = ma * mb;
  end

  // Cosine magnitude, limited to one, and its sign.
  assign adot  = dot[33] ? 34'(-dot) : 34'(dot);
  assign mag   = (q > ONE) ? ONE : q;
  assign mag_s = signed'({1'b0, mag});
  assign cos_w = (dot > 0) ? -mag_s : mag_s;

  // Store port: corner reads during a query, one write at the end of a load.
  assign off      = (cnt[0] ? AW'(1) : '0) + (cnt[1] ? STEP_Y : '0) + (cnt[2] ? STEP_Z : '0);
  assign mem_we   = (state == S_WRITE);
  assign mem_addr = (state == S_WRITE) ? item.addr[AW-1:0] : item.addr[AW-1:0] + off;
  assign mem_wd   = ld_deg ? {1'b1, {VB{1'b0}}} : {1'b0, cos_w};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wd;
    end
    mem_rd <= mem[mem_addr];
  end

  // One linear interpolation per cycle from the two oldest list entries.
  always_comb begin
    if (cnt < 6'd4) begin
      fsel = item.fx[FRAC_BITS-1:0];
    end else if (cnt < 6'd6) begin
      fsel = item.fy[FRAC_BITS-1:0];
    end else begin
      fsel = item.fz[FRAC_BITS-1:0];
    end
    diff   = {lv[1][VB-1], lv[1]} - {lv[0][VB-1], lv[0]};
    t      = LW'(diff) * LW'(signed'({1'b0, fsel})) + (LW'(1) << (FRAC_BITS - 1));
    lres   = LW'(lv[0]) + (t >>> FRAC_BITS);
    lerp_r = lres[VB-1:0];
    if (lerp_r > signed'({1'b0, ONE})) begin
      cclamp = signed'({1'b0, ONE});
    end else if (lerp_r < -signed'({1'b0, ONE})) begin
      cclamp = -signed'({1'b0, ONE});
    end else begin
      cclamp = lerp_r;
    end
    ins = 3'd6 - cnt[2:0];
  end

  // Rotation step and final angle mapping.
  always_comb begin
    xs     = x >>> cnt[4:0];
    ys     = y >>> cnt[4:0];
    atan_s = signed'(ZW'(atan_q16(cnt[4:0])));
    zz     = neg ? (ZW'(PI_Q16) - z) : z;
    zc     = (zz < 0) ? '0 : zz;
    za     = (zc + ZW'(4)) >>> 3;
    acsq   = (2*VB-2)'(ac) * (2*VB-2)'(ac);
  end

  // Sequencer for both request kinds.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      done     <= 1'b0;
      sq_start <= 1'b0;
    end else begin
      done     <= 1'b0;
      sq_start <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            item <= q_item;
            cnt  <= '0;
            dot  <= '0;
            nf   <= '0;
            ns   <= '0;
            deg  <= 1'b0;
            unique case (q_item.op)
              OP_LOAD:  state <= S_MUL;
              OP_QUERY: state <= S_READ;
              OP_MISS: begin
                done              <= 1'b1;
                angle             <= '0;
                status            <= 1'b1;
                degenerate_corner <= 1'b0;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_MUL: begin
          if (cnt < 6'd3) begin
            dot <= dot + 34'(prod);
          end else if (cnt < 6'd6) begin
            nf <= nf + 32'(prod);
          end else begin
            ns <= ns + 32'(prod);
          end
          cnt <= cnt + 6'd1;
          if (cnt == 6'd8) begin
            state <= S_PROD;
          end
        end
        S_PROD: begin
          rad      <= 64'(nf) * 64'(ns);
          sq_start <= 1'b1;
          state    <= S_PSQRT;
        end
        S_PSQRT: begin
          if (sq_done) begin
            cnt    <= '0;
            q      <= '0;
            ld_deg <= (sq_root == '0);
            num    <= (64'(adot) << (VB - 1)) + 64'(sq_root);
            den_sh <= 64'(sq_root) << (VB - 1);
            state  <= (sq_root == '0) ? S_WRITE : S_DIV;
          end
        end
        S_DIV: begin
          if (num >= den_sh) begin
            num <= num - den_sh;
            q   <= {q[VB-3:0], 1'b1};
          end else begin
            q   <= {q[VB-3:0], 1'b0};
          end
          den_sh <= den_sh >> 1;
          cnt    <= cnt + 6'd1;
          if (cnt == 6'(VB - 2)) begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          state <= S_IDLE;
        end
        S_READ: begin
          if (cnt != 6'd0) begin
            for (int k = 0; k < 7; k++) begin
              lv[k] <= lv[k+1];
            end
            lv[7] <= mem_rd[VB-1:0];
            deg   <= deg | mem_rd[EW-1];
          end
          cnt <= cnt + 6'd1;
          if (cnt == 6'd8) begin
            cnt   <= '0;
            state <= S_LERP;
          end
        end
        S_LERP: begin
          for (int k = 0; k < 6; k++) begin
            lv[k] <= lv[k+2];
          end
          lv[ins] <= lerp_r;
          cnt     <= cnt + 6'd1;
          if (cnt == 6'd6) begin
            neg   <= cclamp[VB-1];
            ac    <= cclamp[VB-1] ? (VB-1)'(-cclamp) : (VB-1)'(cclamp);
            state <= S_SQR;
          end
        end
        S_SQR: begin
          rad      <= (64'(1) << (2*VB - 4)) - 64'(acsq);
          sq_start <= 1'b1;
          state    <= S_ASQRT;
        end
        S_ASQRT: begin
          if (sq_done) begin
            x     <= XW'(ac);
            y     <= XW'(sq_root);
            z     <= '0;
            cnt   <= '0;
            state <= (sq_root == '0) ? S_FINISH : S_CORDIC;
          end
        end
        S_CORDIC: begin
          if (y >= 0) begin
            x <= x + ys;
            y <= y - xs;
            z <= z + atan_s;
          end else begin
            x <= x - ys;
            y <= y + xs;
            z <= z - atan_s;
          end
          cnt <= cnt + 6'd1;
          if (cnt == 6'(CORDIC_STEPS - 1)) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          done              <= 1'b1;
          status            <= 1'b0;
          degenerate_corner <= deg;
          angle             <= (za > ZW'(ANGLE_MAX)) ? ANGLE_MAX : za[ANGLE_BITS-1:0];
          state             <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/contact_angle_trilinear_interp.sv =====
// Top level of the contact-angle interpolator: front end, queue and back end.
//
// A request is taken when start is high and busy is low. A load (kind 0) writes
// the cosine of the contact angle for one grid point and returns nothing; a query
// (kind 1) returns one result, shown for exactly one cycle with done high, and the
// receiver cannot stall it. A staging register and a two-entry queue let several
// requests be taken while the back end works. The back end handles one request at
// a time: a load does nine products on one multiplier, a square root and a
// bit-serial divide; a query does eight corner reads from the single-port store,
// seven interpolation steps, the square root and 17 rotation steps; a query
// outside the grid is answered straight from the idle state.
// The store has no reset; a query may only touch points loaded since reset.
`include "contact_angle_trilinear_interp_assert.svh"

module contact_angle_trilinear_interp import cati_pkg::*; #(
  parameter int GRID_X     = 32,
  parameter int GRID_Y     = 32,
  parameter int GRID_Z     = 32,
  parameter int FRAC_BITS  = 12,
  parameter int VALUE_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        kind,
  input  logic [POS_BITS-1:0]         pos_x,
  input  logic [POS_BITS-1:0]         pos_y,
  input  logic [POS_BITS-1:0]         pos_z,
  input  logic signed [GRAD_BITS-1:0] fluid_gx,
  input  logic signed [GRAD_BITS-1:0] fluid_gy,
  input  logic signed [GRAD_BITS-1:0] fluid_gz,
  input  logic signed [GRAD_BITS-1:0] solid_gx,
  input  logic signed [GRAD_BITS-1:0] solid_gy,
  input  logic signed [GRAD_BITS-1:0] solid_gz,
  output logic                        done,
  output logic [ANGLE_BITS-1:0]       angle,
  output logic                        status,
  output logic                        degenerate_corner
);

  logic       q_push, q_full, q_pop, q_empty;
  cati_item_t push_item, pop_item;

  cati_front #(
    .GRID_X    (GRID_X),
    .GRID_Y    (GRID_Y),
    .GRID_Z    (GRID_Z),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .kind     (kind),
    .pos_x    (pos_x),
    .pos_y    (pos_y),
    .pos_z    (pos_z),
    .fluid_gx (fluid_gx),
    .fluid_gy (fluid_gy),
    .fluid_gz (fluid_gz),
    .solid_gx (solid_gx),
    .solid_gy (solid_gy),
    .solid_gz (solid_gz),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (push_item)
  );

  cati_queue #(
    .W ($bits(cati_item_t))
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (push_item),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (pop_item),
    .empty (q_empty)
  );

  cati_back #(
    .GRID_X     (GRID_X),
    .GRID_Y     (GRID_Y),
    .GRID_Z     (GRID_Z),
    .FRAC_BITS  (FRAC_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk               (clk),
    .rst               (rst),
    .q_empty           (q_empty),
    .q_item            (pop_item),
    .q_pop             (q_pop),
    .done              (done),
    .angle             (angle),
    .status            (status),
    .degenerate_corner (degenerate_corner)
  );

  // A cell outside the grid reports a zero angle and no degenerate corner.
  `CATI_ASSERT_NOW(a_miss_clean, done && status, angle == '0 && !degenerate_corner, "miss result not clean")
  // Every reported angle lies in zero to pi.
  `CATI_ASSERT_NOW(a_angle_range, done, angle <= ANGLE_MAX, "angle out of range")
  // The front end never pushes into a full queue.
  `CATI_ASSERT_NOW(a_no_overfill, q_push, !q_full, "push into full queue")
  // Without a pop the front end stays blocked.
  `CATI_ASSERT_NEXT(a_busy_holds, busy && !q_pop, busy, "busy dropped without a pop")

endmodule
